// ===== src/mchw_pkg.sv =====
// ----------------------------------------------------------------------------
// mchw_pkg - shared types and constants for the hang watchdog
// Operation codes, event kinds, register indexes and the sequencer states.
// ----------------------------------------------------------------------------
package mchw_pkg;

  // Operation codes carried by an input beat
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_ACTIVITY   = 3'd1;
  localparam logic [2:0] OP_WAIT       = 3'd2;
  localparam logic [2:0] OP_REGISTER   = 3'd3;
  localparam logic [2:0] OP_UNREGISTER = 3'd4;

  // Event kinds reported on the result port
  localparam logic [1:0] EV_HANG_START = 2'd0;
  localparam logic [1:0] EV_HANG_END   = 2'd1;
  localparam logic [1:0] EV_PERMA      = 2'd2;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] REG_HANG_TIMEOUT  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PERMA_TIMEOUT = 4'd1;

  // Timeout value that never fires
  localparam logic [31:0] NEVER_FIRES = 32'hFFFF_FFFF;

  // At most this many events are reported per tick
  localparam int unsigned MAX_EVENTS = 8;
  localparam int unsigned EV_CNT_W   = 4;

  // Scan sequencer states
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SCAN  = 4'b0010,
    ST_LAST  = 4'b0100,
    ST_FLUSH = 4'b1000
  } seq_state_t;

endpackage

// ===== src/multi_channel_hang_watchdog_unit.sv =====
// ----------------------------------------------------------------------------
// multi_channel_hang_watchdog_unit - multi-channel hang watchdog
// A shared time counter and per-channel idle tracking. A tick scans the
// channels one per cycle through a single compare unit and reports hang
// start, hang end and permanent-hang events.
// ----------------------------------------------------------------------------
//
//  channel   | handshake                     | payload
//  ----------+-------------------------------+-----------------------------------
//  command   | start / busy                  | opcode, channel
//  config    | cfg_valid / cfg_ready         | cfg_index, cfg_data
//  events    | event_strobe (no backpressure)| event_kind, event_channel,
//            |                               | hang_length, last_event
//
// A tick keeps busy high through the scan: ST_SCAN steps through the channels
// (memory read, then compare), ST_LAST finishes the last compare and ST_FLUSH
// flushes the held-back final event. Activity, wait, register and unregister
// complete at the accepting edge; busy stays low.
// Events leave one per strobe; the last one of a tick carries last_event.
// Reset clears time, hanging and present; sets waiting and timeouts (never-fire).
// ----------------------------------------------------------------------------
module multi_channel_hang_watchdog_unit #(
  parameter int unsigned CHANNELS  = 8,
  parameter int unsigned TIME_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  // command beat
  input  logic                           start,
  output logic                           busy,
  input  logic [2:0]                     opcode,
  input  logic [2:0]                     channel,
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [mchw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                    cfg_data,
  // event beats
  output logic                           event_strobe,
  output logic [1:0]                     event_kind,
  output logic [2:0]                     event_channel,
  output logic [31:0]                    hang_length,
  output logic                           last_event
);

  import mchw_pkg::*;

  localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned CHW   = (IDX_W > 3) ? IDX_W + 1 : 4;
  localparam int unsigned CMPW  = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CHANNELS - 1);

  // Configuration and time
  logic [31:0]          hang_timeout;
  logic [31:0]          perma_timeout;
  logic [TIME_BITS-1:0] now_time;

  // Per-channel flags
  logic [CHANNELS-1:0] is_hanging;
  logic [CHANNELS-1:0] is_waiting;
  logic [CHANNELS-1:0] is_present;

  // Per-channel time stamps
  logic [TIME_BITS-1:0] last_activity [CHANNELS];
  logic [TIME_BITS-1:0] hang_begin    [CHANNELS];
  logic [TIME_BITS-1:0] la_q;
  logic [TIME_BITS-1:0] hb_q;

  // Sequencer
  seq_state_t     state;
  logic [IDX_W-1:0] rd_idx;
  logic [IDX_W-1:0] ev_idx;
  logic             ev_vld;
  logic [EV_CNT_W-1:0] evt_cnt;

  // Held-back event
  logic        pend_vld;
  logic [1:0]  pend_kind;
  logic [2:0]  pend_ch;
  logic [31:0] pend_len;

  // Command decode
  logic             cmd_go;
  logic             tick_go;
  logic [CHW-1:0]   ch_wide;
  logic             ch_ok;
  logic [IDX_W-1:0] ch_idx;
  logic             la_we;
  logic             hb_cmd_we;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign cmd_go    = start && !busy;
  assign tick_go   = cmd_go && (opcode == OP_TICK);
  assign ch_wide   = CHW'(channel);
  assign ch_ok     = ch_wide < CHW'(CHANNELS);
  assign ch_idx    = ch_wide[IDX_W-1:0];

  always_comb begin
    la_we     = 1'b0;
    hb_cmd_we = 1'b0;
    if (cmd_go && ch_ok) begin
      if ((opcode == OP_ACTIVITY || opcode == OP_WAIT) && is_present[ch_idx]) begin
        la_we = 1'b1;
      end
      if (opcode == OP_REGISTER && !is_present[ch_idx]) begin
        la_we     = 1'b1;
        hb_cmd_we = 1'b1;
      end
    end
  end

  // Shared compare unit: evaluates the channel read in the previous cycle
  logic [TIME_BITS-1:0] idle;
  logic [TIME_BITS-1:0] len;
  logic [CMPW-1:0]      idle_w;
  logic [CMPW-1:0]      len_w;
  logic                 active;
  logic                 perma_hit;
  logic                 hang_hit;
  logic                 new_ev;
  logic [1:0]           new_kind;
  logic [31:0]          new_len;
  logic                 set_waiting;
  logic                 set_hanging;
  logic                 clr_hanging;
  logic                 keep_ev;
  logic [CHW-1:0]       ev_wide;

  assign idle      = now_time - la_q;
  assign len       = now_time - hb_q;
  assign idle_w    = CMPW'(idle);
  assign len_w     = CMPW'(len);
  assign active    = ev_vld && is_present[ev_idx] && !is_waiting[ev_idx];
  assign perma_hit = (perma_timeout != NEVER_FIRES) && (idle_w >= CMPW'(perma_timeout));
  assign hang_hit  = (hang_timeout != NEVER_FIRES) && (idle_w >= CMPW'(hang_timeout));
  assign ev_wide   = CHW'(ev_idx);

  always_comb begin
    new_ev      = 1'b0;
    new_kind    = EV_HANG_START;
    new_len     = '0;
    set_waiting = 1'b0;
    set_hanging = 1'b0;
    clr_hanging = 1'b0;
    if (active) begin
      priority if (perma_hit) begin
        set_waiting = 1'b1;
        new_ev      = 1'b1;
        new_kind    = EV_PERMA;
      end else if (!is_hanging[ev_idx]) begin
        if (hang_hit) begin
          set_hanging = 1'b1;
          new_ev      = 1'b1;
          new_kind    = EV_HANG_START;
        end
      end else if (la_q != hb_q) begin
        clr_hanging = 1'b1;
        new_ev      = 1'b1;
        new_kind    = EV_HANG_END;
        new_len     = len_w[31:0];
      end else begin
        // still hanging, no activity since the hang began
      end
    end
  end

  assign keep_ev = new_ev && (evt_cnt < EV_CNT_W'(MAX_EVENTS));

  // Time stamp memories: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (la_we) begin
      last_activity[ch_idx] <= now_time;
    end
    if (hb_cmd_we) begin
      hang_begin[ch_idx] <= now_time;
    end else if (set_hanging) begin
      hang_begin[ev_idx] <= la_q;
    end
    la_q <= last_activity[rd_idx];
    hb_q <= hang_begin[rd_idx];
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hang_timeout  <= NEVER_FIRES;
      perma_timeout <= NEVER_FIRES;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_HANG_TIMEOUT) begin
        hang_timeout <= cfg_data;
      end
      if (cfg_index == REG_PERMA_TIMEOUT) begin
        perma_timeout <= cfg_data;
      end
    end
  end

  // Time counter and channel flags
  always_ff @(posedge clk) begin
    if (rst) begin
      now_time   <= '0;
      is_hanging <= '0;
      is_waiting <= '1;
      is_present <= '0;
    end else begin
      if (tick_go) begin
        now_time <= now_time + TIME_BITS'(1);
      end
      if (cmd_go && ch_ok) begin
        unique case (opcode)
          OP_ACTIVITY, OP_WAIT: begin
            if (is_present[ch_idx]) begin
              is_waiting[ch_idx] <= (opcode == OP_WAIT);
            end
          end
          OP_REGISTER: begin
            if (!is_present[ch_idx]) begin
              is_present[ch_idx] <= 1'b1;
              is_hanging[ch_idx] <= 1'b0;
              is_waiting[ch_idx] <= 1'b1;
            end
          end
          OP_UNREGISTER: begin
            is_present[ch_idx] <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (set_waiting) begin
        is_waiting[ev_idx] <= 1'b1;
      end
      if (set_hanging) begin
        is_hanging[ev_idx] <= 1'b1;
      end
      if (clr_hanging) begin
        is_hanging[ev_idx] <= 1'b0;
      end
    end
  end

  // Scan sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      rd_idx <= '0;
      ev_vld <= 1'b0;
    end else begin
      ev_vld <= (state == ST_SCAN);
      ev_idx <= rd_idx;
      unique case (state)
        ST_IDLE: begin
          rd_idx <= '0;
          if (tick_go) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (rd_idx == LAST_IDX) begin
            state <= ST_LAST;
          end else begin
            rd_idx <= rd_idx + IDX_W'(1);
          end
        end
        ST_LAST: begin
          state <= ST_FLUSH;
        end
        ST_FLUSH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Event output: each event is held back one slot so the final one can be
  // flagged once the scan is over
  always_ff @(posedge clk) begin
    if (rst) begin
      event_strobe <= 1'b0;
      pend_vld     <= 1'b0;
      evt_cnt      <= '0;
    end else begin
      event_strobe <= 1'b0;
      if (tick_go) begin
        pend_vld <= 1'b0;
        evt_cnt  <= '0;
      end
      if (keep_ev) begin
        if (pend_vld) begin
          event_strobe  <= 1'b1;
          event_kind    <= pend_kind;
          event_channel <= pend_ch;
          hang_length   <= pend_len;
          last_event    <= 1'b0;
        end
        pend_vld  <= 1'b1;
        pend_kind <= new_kind;
        pend_ch   <= ev_wide[2:0];
        pend_len  <= new_len;
        evt_cnt   <= evt_cnt + EV_CNT_W'(1);
      end
      if (state == ST_FLUSH) begin
        if (pend_vld) begin
          event_strobe  <= 1'b1;
          event_kind    <= pend_kind;
          event_channel <= pend_ch;
          hang_length   <= pend_len;
          last_event    <= 1'b1;
        end
        pend_vld <= 1'b0;
      end
    end
  end

  // Checks
  a_strobe_after_scan: assert property (@(posedge clk) disable iff (rst)
    event_strobe |-> $past(busy))
    else $error("event beat without a tick in progress");

  a_last_has_strobe: assert property (@(posedge clk) disable iff (rst)
    (event_strobe && last_event) |-> ($past(state) == ST_FLUSH))
    else $error("final event flagged outside the flush step");

  a_flush_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |=> (state == ST_IDLE && !pend_vld))
    else $error("flush did not empty the held event");

  a_event_limit: assert property (@(posedge clk) disable iff (rst)
    evt_cnt <= EV_CNT_W'(MAX_EVENTS))
    else $error("too many events in one tick");

  a_tick_starts_scan: assert property (@(posedge clk) disable iff (rst)
    tick_go |=> (state == ST_SCAN && rd_idx == '0))
    else $error("tick did not start a scan");

endmodule
